@@ design/tclr_pkg.sv @@
// Package with the shared types and constants of the TTL cache directory.
package tclr_pkg;

  // Number of cache slots and the widths that follow from it.
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int OUT_IDX_W = 4;

  // Request types.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // One request item.
  typedef struct packed {
    logic               req_type;
    logic [31:0]        key;
    logic [31:0]        now_seconds;
    logic signed [31:0] max_age;
  } req_t;

  // One response item.
  typedef struct packed {
    logic                 hit;
    logic                 fresh;
    logic                 stored;
    logic [OUT_IDX_W-1:0] entry_index;
  } rsp_t;

  // Scan token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic             req_type;
    logic [31:0]      key;
    logic [31:0]      now;
    logic             hit;
    logic             fresh;
    logic [IDX_W-1:0] hit_idx;
    logic             stale_found;
    logic [IDX_W-1:0] stale_idx;
    logic [31:0]      oldest;
    logic [IDX_W-1:0] oldest_idx;
  } tok_t;

  // Slot write broadcast to all cells at the end of a scan.
  typedef struct packed {
    logic             en;
    logic             touch_only;
    logic [IDX_W-1:0] idx;
    logic [31:0]      key;
    logic [31:0]      max_age;
    logic [31:0]      now;
  } wr_t;

endpackage

@@ design/tclr_cell.sv @@
// One cache slot: holds its entry and updates the passing scan token.
module tclr_cell
  import tclr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] my_index,
  input  logic [CNT_W-1:0] fill_count,
  input  tok_t             tok_in,
  input  wr_t              wr,
  output tok_t             tok_out
);

  logic [31:0] entry_key;
  logic [31:0] entry_max_age;
  logic [31:0] entry_cached_time;
  logic [31:0] entry_access_time;

  logic        filled;
  logic [31:0] age;
  logic        stale;
  tok_t        tok_next;

  // Age saturates at zero when the clock is behind the cached time.
  always_comb begin
    filled = CNT_W'(my_index) < fill_count;
    age    = (tok_in.now >= entry_cached_time) ? (tok_in.now - entry_cached_time) : 32'd0;
    stale  = entry_max_age[31] | (age >= entry_max_age);
  end

  // Token update: first key match, first stale slot and oldest access time.
  always_comb begin
    tok_next = tok_in;
    if (tok_in.req_type == REQ_LOOKUP) begin
      if (!tok_in.hit && filled && (entry_key == tok_in.key)) begin
        tok_next.hit     = 1'b1;
        tok_next.hit_idx = my_index;
        tok_next.fresh   = !stale;
      end
    end else begin
      if (!tok_in.stale_found && stale) begin
        tok_next.stale_found = 1'b1;
        tok_next.stale_idx   = my_index;
      end
      if ((my_index == '0) || (entry_access_time < tok_in.oldest)) begin
        tok_next.oldest     = entry_access_time;
        tok_next.oldest_idx = my_index;
      end
    end
  end

  // Token register toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    if (tok_in.valid) begin
      tok_out.req_type    <= tok_next.req_type;
      tok_out.key         <= tok_next.key;
      tok_out.now         <= tok_next.now;
      tok_out.hit         <= tok_next.hit;
      tok_out.fresh       <= tok_next.fresh;
      tok_out.hit_idx     <= tok_next.hit_idx;
      tok_out.stale_found <= tok_next.stale_found;
      tok_out.stale_idx   <= tok_next.stale_idx;
      tok_out.oldest      <= tok_next.oldest;
      tok_out.oldest_idx  <= tok_next.oldest_idx;
    end
  end

  // Slot storage, written by the broadcast from the controller.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == my_index)) begin
      entry_access_time <= wr.now;
      if (!wr.touch_only) begin
        entry_key         <= wr.key;
        entry_max_age     <= wr.max_age;
        entry_cached_time <= wr.now;
      end
    end
  end

endmodule

@@ design/ttl_cache_lookup_replace.sv @@
// Top level of the TTL cache directory: controller and the row of slot cells.
//
// A cache directory of ENTRIES slots keyed by a 32-bit tag. Each item is a
// lookup or an insert. A scan token enters the first slot cell the cycle after
// the item is accepted and moves one cell per cycle down the row. The next item
// is accepted only once the token has left the last cell and the result of the
// item has been registered. Any slot write (new entry, or the access-time
// refresh of a fresh hit) is applied in the cycle the result is registered, so
// the next item always sees it. One item is in work at a time; the result waits
// in an output register, and the next item may be accepted while it is still
// stalled.
module ttl_cache_lookup_replace
  import tclr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [1:0] {IDLE, SCAN, RESOLVE} state_t;

  state_t           state;
  logic [CNT_W-1:0] fill_count;
  tok_t             launch;
  tok_t             tok [ENTRIES];
  tok_t             tok_last;
  wr_t              wr;
  rsp_t             rsp_next;
  logic [CNT_W-1:0] fill_next;
  logic             req_accept;
  logic             rsp_free;
  logic             full;

  // Freshness limit of the item in work, held beside the launch token.
  logic [31:0] req_max_age;

  assign tok_last   = tok[ENTRIES-1];
  assign req_stall  = (state != IDLE);
  assign req_accept = req_valid && !req_stall;
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign full       = (fill_count == CNT_W'(ENTRIES));

  // Row of slot cells.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tclr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .my_index  (IDX_W'(i)),
      .fill_count(fill_count),
      .tok_in    ((i == 0) ? launch : tok[(i == 0) ? 0 : i - 1]),
      .wr        (wr),
      .tok_out   (tok[i])
    );
  end

  // Result and slot write once the token has left the last cell.
  always_comb begin
    rsp_next   = '0;
    wr         = '0;
    wr.key     = launch.key;
    wr.now     = launch.now;
    wr.max_age = req_max_age;
    fill_next  = fill_count;
    if (state == RESOLVE && rsp_free) begin
      if (tok_last.req_type == REQ_LOOKUP) begin
        rsp_next.hit   = tok_last.hit;
        rsp_next.fresh = tok_last.fresh;
        if (tok_last.hit) begin
          rsp_next.entry_index = OUT_IDX_W'(tok_last.hit_idx);
        end
        if (tok_last.fresh) begin
          wr.en         = 1'b1;
          wr.touch_only = 1'b1;
          wr.idx        = tok_last.hit_idx;
        end
      end else if (!full) begin
        rsp_next.stored      = 1'b1;
        rsp_next.entry_index = OUT_IDX_W'(fill_count);
        wr.en                = 1'b1;
        wr.idx               = IDX_W'(fill_count);
        fill_next            = fill_count + 1'b1;
      end else if (req_max_age != '0) begin
        rsp_next.stored = 1'b1;
        wr.en           = 1'b1;
        wr.idx          = tok_last.stale_found ? tok_last.stale_idx : tok_last.oldest_idx;
        rsp_next.entry_index = OUT_IDX_W'(wr.idx);
      end
    end
  end

  // Controller state, launch token and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      fill_count   <= '0;
      launch.valid <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      launch.valid <= req_accept;
      if (state == RESOLVE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_accept) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (tok_last.valid) begin
            state <= RESOLVE;
          end
        end
        RESOLVE: begin
          if (rsp_free) begin
            fill_count <= fill_next;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
    if (req_accept) begin
      launch.req_type    <= req.req_type;
      launch.key         <= req.key;
      launch.now         <= req.now_seconds;
      launch.hit         <= 1'b0;
      launch.fresh       <= 1'b0;
      launch.hit_idx     <= '0;
      launch.stale_found <= 1'b0;
      launch.stale_idx   <= '0;
      launch.oldest      <= '0;
      launch.oldest_idx  <= '0;
      req_max_age        <= req.max_age;
    end
    if (state == RESOLVE && rsp_free) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ design/tclr_checker.sv @@
// Port-level checker for the TTL cache directory, bound to the top level.
module tclr_checker
  import tclr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // A stalled result holds its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // Only one item is in work: the block stalls right after an accepted item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request not stalled after an item was accepted");

  // A new result appears only at the end of an item in work.
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result appeared with no item in work");

  // Lookup flags and the insert flag never appear together, and fresh comes only with a hit.
  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.hit || rsp.fresh) |-> !rsp.stored && rsp.hit)
    else $error("inconsistent result flags");

  // With no match and nothing stored the slot number is zero.
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.hit && !rsp.stored |-> rsp.entry_index == '0)
    else $error("slot number set on an empty result");

endmodule

bind ttl_cache_lookup_replace tclr_checker u_tclr_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);
